[hdl/bte1_pkg.sv]
// Package for the E1 authentication pipeline: beat types, tables and helpers.
package bte1_pkg;

  localparam int NumRounds = 8;
  localparam logic [15:0] XOR_POS_MASK = 16'h9999;
  localparam logic [15:0] OFFSET_ADD_MASK = 16'hAA55;

  typedef logic [7:0] rom_t [256];
  typedef logic [3:0] shuf_t [16];
  typedef logic [7:0] offs_t [8];

  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] rand_low;
    logic [63:0] rand_high;
    logic [47:0] bd_address;
  } req_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } res_t;

  // One pipeline slot: cipher state, key in use, round-1 input, address.
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] key;
    logic [127:0] orig;
    logic [47:0]  addr;
  } stage_t;

  localparam shuf_t SHUFFLE = '{4'd8, 4'd11, 4'd12, 4'd15, 4'd2, 4'd1, 4'd6, 4'd5,
                                4'd10, 4'd9, 4'd14, 4'd13, 4'd0, 4'd7, 4'd4, 4'd3};
  localparam offs_t OFFSET_TAB = '{8'd233, 8'd229, 8'd223, 8'd193,
                                   8'd179, 8'd167, 8'd149, 8'd131};

  // Powers of 45 mod 257, with 256 folded to 0.
  function automatic rom_t build_exp();
    rom_t t;
    int   r;
    r = 1;
    for (int i = 0; i < 256; i++) begin
      t[i] = r[7:0];
      r = (r * 45) % 257;
    end
    return t;
  endfunction

  function automatic rom_t build_log();
    rom_t e;
    rom_t l;
    e = build_exp();
    for (int i = 0; i < 256; i++) begin
      l[e[i]] = i[7:0];
    end
    return l;
  endfunction

  localparam rom_t EXP_ROM = build_exp();
  localparam rom_t LOG_ROM = build_log();

  // Byte i takes xor at the marked positions, add elsewhere.
  function automatic logic [127:0] mix(input logic [127:0] a, input logic [127:0] b);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = XOR_POS_MASK[i] ? (a[8*i +: 8] ^ b[8*i +: 8])
                                    : (a[8*i +: 8] + b[8*i +: 8]);
    end
    return r;
  endfunction

  // Subkey p (1..17); only called with constant p, so it folds to wiring and adders.
  function automatic logic [127:0] round_key(input logic [127:0] key, input int p);
    logic [7:0]   regs [17];
    logic [127:0] r;
    logic [15:0]  dbl;
    int           idx;
    int           rot;
    int           bidx;
    regs[16] = 8'd0;
    for (int i = 0; i < 16; i++) begin
      regs[i] = key[8*i +: 8];
      regs[16] = regs[16] ^ key[8*i +: 8];
    end
    rot = (3 * (p - 1)) & 7;
    for (int i = 0; i < 16; i++) begin
      idx = p - 1 + i;
      if (idx >= 17) idx = idx - 17;
      dbl = {regs[idx], regs[idx]} << rot;
      bidx = (17 * p + i + 1) & 255;
      r[8*i +: 8] = dbl[15:8] + EXP_ROM[EXP_ROM[bidx[7:0]]];
    end
    return (p == 1) ? key : r;
  endfunction

  // Four pseudo-Hadamard layers with the shuffle between them.
  function automatic logic [127:0] pht(input logic [127:0] s);
    logic [127:0] c;
    logic [127:0] t;
    logic [7:0]   a;
    logic [7:0]   b;
    c = s;
    for (int layer = 0; layer < 4; layer++) begin
      for (int i = 0; i < 16; i += 2) begin
        a = c[8*i +: 8];
        b = c[8*(i+1) +: 8];
        c[8*i +: 8] = {a[6:0], 1'b0} + b;
        c[8*(i+1) +: 8] = a + b;
      end
      if (layer != 3) begin
        for (int i = 0; i < 16; i++) t[8*i +: 8] = c[8*SHUFFLE[i] +: 8];
        c = t;
      end
    end
    return c;
  endfunction

endpackage

[hdl/bte1_round.sv]
// One SAFER+ round as a pipeline stage.
module bte1_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                mix_orig,
  input  logic [127:0]        ka,
  input  logic [127:0]        kb,
  input  logic                in_valid,
  input  bte1_pkg::stage_t    in_stage,
  output logic                out_valid,
  output bte1_pkg::stage_t    out_stage
);

  logic [127:0] pre;
  logic [127:0] keyed;
  logic [127:0] sub;
  logic [127:0] added;

  always_comb begin
    pre = mix_orig ? bte1_pkg::mix(in_stage.state, in_stage.orig) : in_stage.state;
    keyed = bte1_pkg::mix(pre, ka);
    for (int i = 0; i < 16; i++) begin
      if (bte1_pkg::XOR_POS_MASK[i]) begin
        sub[8*i +: 8] = bte1_pkg::EXP_ROM[keyed[8*i +: 8]];
        added[8*i +: 8] = sub[8*i +: 8] + kb[8*i +: 8];
      end else begin
        sub[8*i +: 8] = bte1_pkg::LOG_ROM[keyed[8*i +: 8]];
        added[8*i +: 8] = sub[8*i +: 8] ^ kb[8*i +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stage.state <= bte1_pkg::pht(added);
      out_stage.key   <= in_stage.key;
      out_stage.orig  <= in_stage.orig;
      out_stage.addr  <= in_stage.addr;
    end
  end

endmodule

[hdl/bte1_join.sv]
// Stage between the two ciphers: builds Ar' input and the offset key.
module bte1_join (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  bte1_pkg::stage_t    in_stage,
  output logic                out_valid,
  output bte1_pkg::stage_t    out_stage
);

  logic [127:0] ar_out;
  logic [127:0] x;
  logic [127:0] okey;
  logic [7:0]   c;

  always_comb begin
    ar_out = bte1_pkg::mix(in_stage.state, bte1_pkg::round_key(in_stage.key, 17));
    for (int i = 0; i < 16; i++) begin
      x[8*i +: 8] = in_stage.addr[8*(i%6) +: 8]
                    + (ar_out[8*i +: 8] ^ in_stage.orig[8*i +: 8]);
      c = bte1_pkg::OFFSET_TAB[i%8];
      okey[8*i +: 8] = bte1_pkg::OFFSET_ADD_MASK[i] ? (in_stage.key[8*i +: 8] + c)
                                                     : (in_stage.key[8*i +: 8] ^ c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stage.state <= x;
      out_stage.key   <= okey;
      out_stage.orig  <= x;
      out_stage.addr  <= in_stage.addr;
    end
  end

endmodule

[hdl/bluetooth_e1_authentication.sv]
// E1 authentication: Ar then Ar' (SAFER+), one round per pipeline stage.
// Pipeline stages from an accepted req beat to res_valid: 8 Ar rounds,
// one join stage, 8 Ar' rounds, one output stage.
// Throughput: one beat per cycle; a stall on res freezes the whole pipe.
// Reset (rst, synchronous): clears all stage valid bits; no other state.
module bluetooth_e1_authentication (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bte1_pkg::req_t    req,
  output logic              res_valid,
  input  logic              res_stall,
  output bte1_pkg::res_t    res
);

  localparam int Stages = 2 * bte1_pkg::NumRounds + 2;

  // Pipe moves as a unit whenever the output register can take a beat.
  logic advance;
  assign advance   = !(res_valid && res_stall);
  assign req_stall = !advance;

  bte1_pkg::stage_t st  [Stages];
  logic             vld [Stages];

  // Slot 0 is the incoming beat, unregistered.
  assign vld[0]      = req_valid;
  assign st[0].state = {req.rand_high, req.rand_low};
  assign st[0].key   = {req.key_high, req.key_low};
  assign st[0].orig  = {req.rand_high, req.rand_low};
  assign st[0].addr  = req.bd_address;

  // Ar: rounds take subkeys 2r-1 and 2r from the key riding with the beat.
  for (genvar g = 0; g < bte1_pkg::NumRounds; g++) begin : g_ar
    logic [127:0] ka;
    logic [127:0] kb;
    assign ka = bte1_pkg::round_key(st[g].key, 2 * g + 1);
    assign kb = bte1_pkg::round_key(st[g].key, 2 * g + 2);
    bte1_round u_round (
      .clk, .rst, .advance,
      .mix_orig  (1'b0),
      .ka, .kb,
      .in_valid  (vld[g]),
      .in_stage  (st[g]),
      .out_valid (vld[g+1]),
      .out_stage (st[g+1])
    );
  end

  bte1_join u_join (
    .clk, .rst, .advance,
    .in_valid  (vld[bte1_pkg::NumRounds]),
    .in_stage  (st[bte1_pkg::NumRounds]),
    .out_valid (vld[bte1_pkg::NumRounds+1]),
    .out_stage (st[bte1_pkg::NumRounds+1])
  );

  // Ar': same rounds under the offset key; round 3 folds in the round-1 input.
  for (genvar g = 0; g < bte1_pkg::NumRounds; g++) begin : g_arp
    localparam int S = bte1_pkg::NumRounds + 1 + g;
    logic [127:0] ka;
    logic [127:0] kb;
    assign ka = bte1_pkg::round_key(st[S].key, 2 * g + 1);
    assign kb = bte1_pkg::round_key(st[S].key, 2 * g + 2);
    bte1_round u_round (
      .clk, .rst, .advance,
      .mix_orig  ((g == 2) ? 1'b1 : 1'b0),
      .ka, .kb,
      .in_valid  (vld[S]),
      .in_stage  (st[S]),
      .out_valid (vld[S+1]),
      .out_stage (st[S+1])
    );
  end

  // Output stage: final subkey mix, held while stalled.
  logic [127:0] fin;
  assign fin = bte1_pkg::mix(st[Stages-1].state, bte1_pkg::round_key(st[Stages-1].key, 17));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= vld[Stages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.result_low  <= fin[63:0];
      res.result_high <= fin[127:64];
    end
  end

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> vld[1])
    else $error("accepted beat did not enter stage 1");

  a_exit: assert property (@(posedge clk) disable iff (rst)
    (vld[Stages-1] && advance) |=> res_valid)
    else $error("last stage beat lost before output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> (vld[Stages-1] == $past(vld[Stages-1])) && $stable(st[Stages-1]))
    else $error("pipe moved during stall");

  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("output valid right after reset");

endmodule

[tb/tb_top.sv]
// Self-checking bench for the E1 authentication pipeline: random and directed beats.
module tb_top;

  // Stand-alone E1 predictor plus an in-order queue of expected results.
  class e1_scoreboard;
    logic [7:0] exp_t [256];
    logic [7:0] log_t [256];
    bte1_pkg::res_t pending [$];
    int         errors;

    function new();
      int r;
      r = 1;
      errors = 0;
      for (int i = 0; i < 256; i++) begin
        exp_t[i] = r[7:0];
        log_t[r[7:0]] = i[7:0];
        r = (r * 45) % 257;
      end
    endfunction

    function bit xpos(int i);
      return ((16'h9999 >> i) & 1) != 0;
    endfunction

    function logic [127:0] combine(logic [127:0] a, logic [127:0] b);
      logic [127:0] o;
      for (int i = 0; i < 16; i++)
        o[8*i +: 8] = xpos(i) ? a[8*i +: 8] ^ b[8*i +: 8] : a[8*i +: 8] + b[8*i +: 8];
      return o;
    endfunction

    function void subkeys(logic [127:0] k, output logic [127:0] sk [18]);
      logic [7:0] rg [17];
      rg[16] = 0;
      for (int i = 0; i < 16; i++) begin
        rg[i] = k[8*i +: 8];
        rg[16] ^= rg[i];
      end
      sk[0] = 0;
      sk[1] = k;
      for (int p = 2; p < 18; p++) begin
        for (int i = 0; i < 17; i++) rg[i] = {rg[i][4:0], rg[i][7:5]};
        for (int i = 0; i < 16; i++)
          sk[p][8*i +: 8] = rg[(p - 1 + i) % 17] + exp_t[exp_t[(17*p + i + 1) % 256]];
      end
    endfunction

    function logic [127:0] safer_ar(logic [127:0] k, logic [127:0] din, bit offs);
      logic [127:0] sk [18];
      logic [127:0] c, t;
      logic [7:0]   a, b;
      int           shuf [16] = '{8, 11, 12, 15, 2, 1, 6, 5, 10, 9, 14, 13, 0, 7, 4, 3};
      subkeys(k, sk);
      c = din;
      for (int r = 1; r <= 8; r++) begin
        if (offs && r == 3) c = combine(c, din);
        c = combine(c, sk[2*r-1]);
        for (int i = 0; i < 16; i++) begin
          c[8*i +: 8] = xpos(i) ? exp_t[c[8*i +: 8]] : log_t[c[8*i +: 8]];
          c[8*i +: 8] = xpos(i) ? c[8*i +: 8] + sk[2*r][8*i +: 8]
                                : c[8*i +: 8] ^ sk[2*r][8*i +: 8];
        end
        for (int l = 0; l < 4; l++) begin
          for (int i = 0; i < 16; i += 2) begin
            a = c[8*i +: 8];
            b = c[8*i+8 +: 8];
            c[8*i +: 8] = 2*a + b;
            c[8*i+8 +: 8] = a + b;
          end
          if (l != 3) begin
            for (int i = 0; i < 16; i++) t[8*i +: 8] = c[8*shuf[i] +: 8];
            c = t;
          end
        end
      end
      return combine(c, sk[17]);
    endfunction

    function void note_request(bte1_pkg::req_t q);
      logic [127:0] k, rn, ar, x, ok, o;
      logic [7:0]   cst;
      bte1_pkg::res_t e;
      int           offv [8] = '{233, 229, 223, 193, 179, 167, 149, 131};
      k = {q.key_high, q.key_low};
      rn = {q.rand_high, q.rand_low};
      ar = safer_ar(k, rn, 0);
      for (int i = 0; i < 16; i++) begin
        x[8*i +: 8] = q.bd_address[8*(i % 6) +: 8] + (ar[8*i +: 8] ^ rn[8*i +: 8]);
        cst = offv[i % 8];
        ok[8*i +: 8] = ((16'hAA55 >> i) & 1) ? k[8*i +: 8] + cst : k[8*i +: 8] ^ cst;
      end
      o = safer_ar(ok, x, 1);
      e.result_low = o[63:0];
      e.result_high = o[127:64];
      pending.push_back(e);
    endfunction

    function void check_result(bte1_pkg::res_t got);
      bte1_pkg::res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.result_low !== want.result_low || got.result_high !== want.result_high) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want %h_%h got %h_%h", want.result_high, want.result_low,
                   got.result_high, got.result_low);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  bte1_pkg::req_t req = '0;
  logic res_valid;
  logic res_stall = 0;
  bte1_pkg::res_t res;
  bit   src_done = 0;
  int   res_wait = 0;
  e1_scoreboard sb = new();

  always #1 clk = ~clk;

  bluetooth_e1_authentication dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Byte patterns biased toward the extremes so exp/log hit 0 and 255 often.
  function automatic logic [63:0] shaped64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {8{8'h80}};
      default: return rnd64();
    endcase
  endfunction

  // Present one request beat after a random gap and hold it until taken.
  task automatic send_req(bte1_pkg::req_t q);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req <= q;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(q);
  endtask

  // Result side: check accepted beats; after each one, draw a random stall that counts down while res_valid.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        sb.check_result(res);
        res_wait = $urandom_range(0, 8);
      end else if (res_valid && res_wait > 0) begin
        res_wait = res_wait - 1;
      end
      res_stall <= (res_wait > 0);
    end
  end

  initial begin
    bte1_pkg::req_t q;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: all-zero, all-one, single fields at extremes, wide address bits.
    for (int d = 0; d < 20; d++) begin
      q.key_low = (d & 1) ? '1 : '0;
      q.key_high = (d & 2) ? '1 : '0;
      q.rand_low = (d & 4) ? '1 : '0;
      q.rand_high = (d & 8) ? '1 : '0;
      q.bd_address = (d & 16) ? '1 : ((d & 1) ? 48'h0 : 48'hFFFF_FFFF_FFFF);
      if (d >= 16) begin
        q.key_low = {8{8'h80}};
        q.rand_low = {8{8'h7F}};
        q.bd_address = {$urandom(), 16'h8001};
      end
      send_req(q);
    end
    for (int n = 0; n < 950; n++) begin
      q.key_low = shaped64();
      q.key_high = shaped64();
      q.rand_low = shaped64();
      q.rand_high = shaped64();
      q.bd_address = ($urandom_range(0, 7) == 0) ? '1 : rnd64();
      send_req(q);
    end
    req_valid <= 0;
    src_done = 1;
  end

  initial begin
    wait (src_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("bluetooth_e1_authentication regression: pass");
    else $display("bluetooth_e1_authentication regression: fail");
    $finish;
  end

  initial begin
    #400000;
    $display("bluetooth_e1_authentication regression: fail");
    $finish;
  end

endmodule

[sim.f]
hdl/bte1_pkg.sv
hdl/bte1_round.sv
hdl/bte1_join.sv
hdl/bluetooth_e1_authentication.sv
tb/tb_top.sv
